// ===== hw/rtl/fvt_pkg.sv =====
// Shared types and constants for the frustum visibility test.
`default_nettype none
package fvt_pkg;

  localparam int CoordW    = 16;
  localparam int RadiusW   = 15;
  localparam int PlaneW    = 64;
  localparam int NumPlanes = 6;
  localparam int CfgIdxW   = 3;
  localparam int AlignSh   = 14;
  localparam int ProdW     = 2 * CoordW;
  localparam int DistW     = ProdW + 2;
  localparam int LimW      = RadiusW + AlignSh + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [DistW-1:0]  dist_t;
  typedef logic signed [LimW-1:0]   lim_t;
  typedef logic [PlaneW-1:0]        plane_t;
  typedef logic [1:0]               mode_t;

  localparam mode_t MODE_BOX    = 2'd0;
  localparam mode_t MODE_POINT  = 2'd1;
  localparam mode_t MODE_SPHERE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_LEFT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TOP    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NEAR   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FAR    = 3'd5;

  localparam plane_t RST_LEFT   = 64'h4000_0000_0000_0010;
  localparam plane_t RST_RIGHT  = 64'hC000_0000_0000_0010;
  localparam plane_t RST_BOTTOM = 64'h0000_4000_0000_0010;
  localparam plane_t RST_TOP    = 64'h0000_C000_0000_0010;
  localparam plane_t RST_NEAR   = 64'h0000_0000_4000_0010;
  localparam plane_t RST_FAR    = 64'h0000_0000_C000_0010;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fvt_plane.sv =====
// One plane's signed-distance pipeline: corner select and multiply, sum, compare.
`default_nettype none
module fvt_plane (
  input  logic               clk,
  input  fvt_pkg::stage_ctl_t ctl,
  input  fvt_pkg::plane_t    plane,
  input  fvt_pkg::mode_t     mode,
  input  fvt_pkg::coord_t    a [3],
  input  fvt_pkg::coord_t    b [3],
  input  fvt_pkg::lim_t      lim,
  output logic               outside_r
);
  import fvt_pkg::*;

  coord_t n    [3];
  coord_t p    [3];
  prod_t  prod_nxt [3];
  prod_t  prod_r   [3];
  coord_t off_r;
  dist_t  dist_nxt;
  dist_t  dist_r;
  logic   outside_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k] = plane[PlaneW-1-CoordW*k -: CoordW];
      p[k] = (mode == MODE_BOX && !n[k][CoordW-1]) ? b[k] : a[k];
      prod_nxt[k] = ProdW'(n[k]) * ProdW'(p[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      off_r <= plane[CoordW-1:0];
    end
  end

  assign dist_nxt = DistW'(prod_r[0]) + DistW'(prod_r[1]) + DistW'(prod_r[2])
                  + (DistW'(off_r) <<< AlignSh);

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      dist_r <= dist_nxt;
    end
  end

  assign outside_nxt = dist_r < DistW'(lim);

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      outside_r <= outside_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/frustum_visibility_test.sv =====
// Six-plane frustum visibility test: plane registers, pipeline control, result register.
// Four-stage pipeline: corner select and 18 16x16 multiplies, per-plane distance sum,
// per-plane outside compare, then the AND of all six into the output register. One
// transaction enters per cycle while in_ready is high. The user writes planes through the
// cfg port (index 0..5: left, right, bottom, top, near, far) only while the pipeline is
// empty; the block does not enforce this. Indexes 6 and 7 are ignored.
`default_nettype none
module frustum_visibility_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fvt_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [fvt_pkg::PlaneW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_x,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_y,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_z,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_x,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_y,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_z,
  input  logic [fvt_pkg::RadiusW-1:0]     in_radius,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_visible
);
  import fvt_pkg::*;

  plane_t plane_r [NumPlanes];
  coord_t a [3];
  coord_t b [3];

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  stage_ctl_t ctl;
  logic ld4;

  lim_t lim_nxt;
  lim_t lim1_r, lim2_r;
  logic [NumPlanes-1:0] outside;
  logic visible_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r[REG_LEFT]   <= RST_LEFT;
      plane_r[REG_RIGHT]  <= RST_RIGHT;
      plane_r[REG_BOTTOM] <= RST_BOTTOM;
      plane_r[REG_TOP]    <= RST_TOP;
      plane_r[REG_NEAR]   <= RST_NEAR;
      plane_r[REG_FAR]    <= RST_FAR;
    end else if (cfg_valid && cfg_index < CfgIdxW'(NumPlanes)) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // Ready chain: a stage takes new data when empty or when it drains.
  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ctl.ld1 = in_valid && rdy1;
  assign ctl.ld2 = v1_r && rdy2;
  assign ctl.ld3 = v2_r && rdy3;
  assign ld4     = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  assign a[0] = in_corner_a_x;
  assign a[1] = in_corner_a_y;
  assign a[2] = in_corner_a_z;
  assign b[0] = in_corner_b_x;
  assign b[1] = in_corner_b_y;
  assign b[2] = in_corner_b_z;

  // Sphere threshold is -radius on the product grid; zero otherwise.
  assign lim_nxt = (in_mode == MODE_SPHERE) ? -(LimW'(in_radius) <<< AlignSh) : '0;

  always_ff @(posedge clk) begin
    if (ctl.ld1) lim1_r <= lim_nxt;
    if (ctl.ld2) lim2_r <= lim1_r;
  end

  for (genvar i = 0; i < NumPlanes; i++) begin : g_plane
    fvt_plane u_plane (
      .clk       (clk),
      .ctl       (ctl),
      .plane     (plane_r[i]),
      .mode      (in_mode),
      .a         (a),
      .b         (b),
      .lim       (lim2_r),
      .outside_r (outside[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ld4) visible_r <= ~|outside;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

`ifndef SYNTH
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  a_s3_drains_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_valid_r |=> out_valid_r)
    else $error("stage 3 result lost");

  a_stall_holds_s3: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && out_valid_r && !out_ready |=> v3_r)
    else $error("stage 3 dropped during stall");

  a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && out_valid_r)
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule
`default_nettype wire

// ===== tb/fvt_checker.sv =====
// Checker for the frustum visibility test: tracks the planes, predicts each result, compares.
`timescale 1ns / 100ps
module fvt_visibility_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [fvt_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [fvt_pkg::PlaneW-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_x,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_y,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_a_z,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_x,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_y,
  input  logic signed [fvt_pkg::CoordW-1:0] in_corner_b_z,
  input  logic [fvt_pkg::RadiusW-1:0]       in_radius,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_visible,
  output int                                fail_count,
  output int                                pending
);
  import fvt_pkg::*;

  plane_t planes [NumPlanes];
  logic   visible_q [$];
  logic   exp_vis;
  int     n_errors = 0;
  int     n_waiting = 0;

  assign fail_count = n_errors;
  assign pending    = n_waiting;

  function automatic logic calc_visible(mode_t m, coord_t ax, coord_t ay, coord_t az,
                                        coord_t bx, coord_t by, coord_t bz,
                                        logic [RadiusW-1:0] r);
    longint pa [3];
    longint pb [3];
    longint nrm [3];
    longint sdist;
    longint lim;
    logic   vis;
    pa[0] = longint'(ax);
    pa[1] = longint'(ay);
    pa[2] = longint'(az);
    pb[0] = longint'(bx);
    pb[1] = longint'(by);
    pb[2] = longint'(bz);
    lim = 0;
    if (m == MODE_SPHERE) begin
      lim = -(longint'(r) * (longint'(1) << AlignSh));
    end
    vis = 1'b1;
    for (int p = 0; p < NumPlanes; p++) begin
      nrm[0] = longint'($signed(planes[p][63:48]));
      nrm[1] = longint'($signed(planes[p][47:32]));
      nrm[2] = longint'($signed(planes[p][31:16]));
      sdist = longint'($signed(planes[p][15:0])) * (longint'(1) << AlignSh);
      for (int k = 0; k < 3; k++) begin
        if (m == MODE_BOX && nrm[k] >= 0) begin
          sdist = sdist + nrm[k] * pb[k];
        end else begin
          sdist = sdist + nrm[k] * pa[k];
        end
      end
      if (sdist < lim) begin
        vis = 1'b0;
      end
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      planes[REG_LEFT]   = RST_LEFT;
      planes[REG_RIGHT]  = RST_RIGHT;
      planes[REG_BOTTOM] = RST_BOTTOM;
      planes[REG_TOP]    = RST_TOP;
      planes[REG_NEAR]   = RST_NEAR;
      planes[REG_FAR]    = RST_FAR;
      visible_q.delete();
      n_waiting <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NumPlanes) begin
        planes[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        visible_q.push_back(calc_visible(in_mode, in_corner_a_x, in_corner_a_y, in_corner_a_z,
                                         in_corner_b_x, in_corner_b_y, in_corner_b_z,
                                         in_radius));
      end
      if (out_valid && out_ready) begin
        if (visible_q.size() == 0) begin
          $error("unexpected result transaction: visible %0b", out_visible);
          n_errors <= n_errors + 1;
        end else begin
          exp_vis = visible_q.pop_front();
          if (out_visible !== exp_vis) begin
            $error("visible mismatch: expected %0b, actual %0b", exp_vis, out_visible);
            n_errors <= n_errors + 1;
          end
        end
      end
      n_waiting <= visible_q.size();
    end
  end

endmodule

// ===== tb/tb_frustum_visibility_test.sv =====
// Testbench top for the frustum visibility test: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_frustum_visibility_test;
  import fvt_pkg::*;

  localparam mode_t               MODE_UNUSED   = 2'd3;
  localparam logic [CfgIdxW-1:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [CfgIdxW-1:0]  REG_SPARE_HI  = 3'd7;
  localparam int                  NumPhases     = 10;
  localparam int                  PhaseItems    = 95;
  localparam int                  HoldCycles    = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [PlaneW-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_mode = MODE_BOX;
  coord_t              in_corner_a_x = '0;
  coord_t              in_corner_a_y = '0;
  coord_t              in_corner_a_z = '0;
  coord_t              in_corner_b_x = '0;
  coord_t              in_corner_b_y = '0;
  coord_t              in_corner_b_z = '0;
  logic [RadiusW-1:0]  in_radius = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_visible;
  int                  fail_count;
  int                  pending;

  plane_t              plane_set [NumPlanes];
  int                  coord_span;
  bit                  burst;
  bit                  want_hold = 1'b0;
  bit                  hold_taken = 1'b0;

  frustum_visibility_test dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_corner_a_x(in_corner_a_x), .in_corner_a_y(in_corner_a_y),
    .in_corner_a_z(in_corner_a_z), .in_corner_b_x(in_corner_b_x),
    .in_corner_b_y(in_corner_b_y), .in_corner_b_z(in_corner_b_z), .in_radius(in_radius),
    .out_valid(out_valid), .out_ready(out_ready), .out_visible(out_visible)
  );

  fvt_visibility_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_corner_a_x(in_corner_a_x), .in_corner_a_y(in_corner_a_y),
    .in_corner_a_z(in_corner_a_z), .in_corner_b_x(in_corner_b_x),
    .in_corner_b_y(in_corner_b_y), .in_corner_b_z(in_corner_b_z), .in_radius(in_radius),
    .out_valid(out_valid), .out_ready(out_ready), .out_visible(out_visible),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic coord_t rand_coord(int span);
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, 2 * span) - span;
      return coord_t'(v);
    end
    return coord_t'($urandom());
  endfunction

  function automatic plane_t pack_plane(int nx, int ny, int nz, int off);
    return {nx[15:0], ny[15:0], nz[15:0], off[15:0]};
  endfunction

  // Output side: random stalls, plus one long hold-off while the sender keeps pushing.
  initial begin
    int g;
    wait (rst_n);
    forever begin
      if (want_hold && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        g = rand_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_query(mode_t m, coord_t ax, coord_t ay, coord_t az,
                            coord_t bx, coord_t by, coord_t bz,
                            logic [RadiusW-1:0] r, int gap);
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_corner_a_x <= ax;
    in_corner_a_y <= ay;
    in_corner_a_z <= az;
    in_corner_b_x <= bx;
    in_corner_b_y <= by;
    in_corner_b_z <= bz;
    in_radius     <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, plane_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_planes();
    write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
    for (int i = 0; i < NumPlanes; i++) begin
      write_reg(CfgIdxW'(i), plane_set[i]);
    end
    write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
  endtask

  // The checker's count is registered, updated by a nonblocking assignment on the accepting edge.
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_query();
    int p;
    mode_t m;
    coord_t ax, ay, az, bx, by, bz;
    logic [RadiusW-1:0] r;
    p = $urandom_range(0, 99);
    m = (p < 35) ? MODE_BOX : (p < 65) ? MODE_POINT : (p < 95) ? MODE_SPHERE : MODE_UNUSED;
    ax = rand_coord(coord_span);
    ay = rand_coord(coord_span);
    az = rand_coord(coord_span);
    if ($urandom_range(0, 9) < 8) begin
      bx = coord_t'(ax + $urandom_range(0, coord_span / 2));
      by = coord_t'(ay + $urandom_range(0, coord_span / 2));
      bz = coord_t'(az + $urandom_range(0, coord_span / 2));
    end else begin
      bx = rand_coord(coord_span);
      by = rand_coord(coord_span);
      bz = rand_coord(coord_span);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = RadiusW'((coord_span > 32767) ? 32767 : $urandom_range(0, coord_span));
    end else begin
      r = RadiusW'($urandom());
    end
    send_query(m, ax, ay, az, bx, by, bz, r, burst ? 0 : rand_gap());
  endtask

  task automatic pick_planes(int ph);
    int w;
    int maxw;
    int nrm [3];
    maxw = 16;
    for (int i = 0; i < NumPlanes; i++) begin
      case (ph)
        2: plane_set[i] = (i % 2) ? 64'h8000_7FFF_8000_7FFF : 64'h7FFF_8000_7FFF_8000;
        4: plane_set[i] = {$urandom(), $urandom()};
        6: plane_set[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        8: plane_set[i] = 64'h0000_0000_0000_0000;
        9: plane_set[i] = '0;
        default: begin
          w = $urandom_range(16, 4096);
          if (w > maxw) maxw = w;
          for (int k = 0; k < 3; k++) nrm[k] = $urandom_range(0, 1024) - 512;
          nrm[i / 2] = (i % 2) ? -16384 : 16384;
          plane_set[i] = pack_plane(nrm[0], nrm[1], nrm[2], w);
        end
      endcase
    end
    if (ph == 9) begin
      plane_set[REG_LEFT]   = RST_LEFT;
      plane_set[REG_RIGHT]  = RST_RIGHT;
      plane_set[REG_BOTTOM] = RST_BOTTOM;
      plane_set[REG_TOP]    = RST_TOP;
      plane_set[REG_NEAR]   = RST_NEAR;
      plane_set[REG_FAR]    = RST_FAR;
      coord_span = 48;
    end else if (ph == 4) begin
      coord_span = 32767;
    end else if (ph == 2 || ph == 6 || ph == 8) begin
      coord_span = 4096;
    end else begin
      coord_span = (2 * maxw + 64 > 32767) ? 32767 : 2 * maxw + 64;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset planes bound the cube [-16, 16] on every axis.
    send_query(MODE_POINT, 0, 0, 0, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, 16, -16, 16, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, 17, 0, 0, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, 0, -17, 0, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, 0, 0, 32767, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, -32768, -32768, -32768, 0, 0, 0, 0, rand_gap());
    send_query(MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0, rand_gap());
    send_query(MODE_BOX, 17, 17, 17, 20, 20, 20, 0, rand_gap());
    send_query(MODE_BOX, 100, 0, 0, 50, 0, 0, 0, rand_gap());
    send_query(MODE_BOX, 10, 0, 0, -10, 0, 0, 0, rand_gap());
    send_query(MODE_BOX, -20, -5, -5, -16, 5, 5, 0, rand_gap());
    send_query(MODE_BOX, 0, 0, 0, 0, 0, 0, 15'h7FFF, rand_gap());
    send_query(MODE_SPHERE, 40, 0, 0, 0, 0, 0, 24, rand_gap());
    send_query(MODE_SPHERE, 40, 0, 0, 0, 0, 0, 23, rand_gap());
    send_query(MODE_SPHERE, -32768, -32768, -32768, 0, 0, 0, 15'h7FFF, rand_gap());
    send_query(MODE_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0, rand_gap());
    send_query(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0, rand_gap());
    send_query(MODE_SPHERE, 5, 5, 5, 32767, 32767, 32767, 0, rand_gap());
    send_query(MODE_UNUSED, 0, 0, 0, 32767, 32767, 32767, 15'h7FFF, rand_gap());
    send_query(MODE_UNUSED, 17, 0, 0, 0, 0, 0, 0, rand_gap());
    send_query(MODE_POINT, 5, 5, 5, -32768, -32768, -32768, 15'h7FFF, 0);
    in_valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      pick_planes(ph);
      load_planes();
      burst = ($urandom_range(0, 3) == 0);
      if (ph == 1) want_hold = 1'b1;
      repeat (PhaseItems) random_query();
      in_valid <= 1'b0;
      wait_idle();
    end

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
